// ===== src/itf_pkg.sv =====
`timescale 1ns / 1ps

package itf_pkg;

  localparam int MAX_WIDTH = 63;
  localparam int NUM_BITS  = 32;
  localparam int NUM_DIGITS = 10;

  localparam logic [2:0] CMD_SDEC = 3'd0;
  localparam logic [2:0] CMD_UDEC = 3'd1;
  localparam logic [2:0] CMD_LHEX = 3'd2;
  localparam logic [2:0] CMD_UHEX = 3'd3;
  localparam logic [2:0] CMD_PTR  = 3'd4;

  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CASE_SHIFT = 8'd32;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] number;
    logic [5:0]  field_width;
    logic        pad_zero;
  } item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIZE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic size;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic cmd_ok;
    logic cmd_dec;
    logic conv_done;
    logic out_free;
    logic emit_last;
  } dp_status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'b0, d};
    end else begin
      ch = CH_LOWER_A + {4'b0, d} - 8'd10;
      if (upper) begin
        ch = ch - CASE_SHIFT;
      end
    end
    return ch;
  endfunction

endpackage

// ===== src/itf_ctrl.sv =====
`timescale 1ns / 1ps

module itf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  itf_pkg::dp_status_t   status,
  output itf_pkg::ctl_cmd_t     cmd
);

  itf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = (state != itf_pkg::ST_IDLE);
    unique case (state)
      itf_pkg::ST_IDLE: begin
        if (item_valid && status.cmd_ok) begin
          cmd.load   = 1'b1;
          state_next = status.cmd_dec ? itf_pkg::ST_CONVERT : itf_pkg::ST_SIZE;
        end
      end
      itf_pkg::ST_CONVERT: begin
        cmd.step = 1'b1;
        if (status.conv_done) begin
          state_next = itf_pkg::ST_SIZE;
        end
      end
      itf_pkg::ST_SIZE: begin
        cmd.size   = 1'b1;
        state_next = itf_pkg::ST_EMIT;
      end
      itf_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_next = itf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = itf_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.size, cmd.emit}))
    else $error("more than one datapath command at once");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("emit while output register is occupied");

  a_size_then_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.size |=> state == itf_pkg::ST_EMIT)
    else $error("size step not followed by emit phase");
`endif

endmodule

// ===== src/itf_dpath.sv =====
`timescale 1ns / 1ps

module itf_dpath (
  input  logic                  clk,
  input  logic                  rst,
  input  itf_pkg::item_t        item,
  output logic                  text_valid,
  input  logic                  text_stall,
  output itf_pkg::text_t        text,
  input  itf_pkg::ctl_cmd_t     cmd,
  output itf_pkg::dp_status_t   status
);

  logic [9:0][3:0] dig;
  logic [31:0]     bin;
  logic [4:0]      cnt;
  logic [5:0]      width;
  logic            neg;
  logic            ptr;
  logic            upper;
  logic            pad_zero;
  logic [1:0]      pre;
  logic [5:0]      pad_left;
  logic [1:0]      pre_left;
  logic [3:0]      dig_left;

  logic            in_neg;
  logic            in_hex;
  logic            in_ptr;
  logic [31:0]     in_mag;
  logic [5:0]      in_width;
  logic [9:0][3:0] adj;
  logic [40:0]     shifted;
  logic [3:0]      ndig;
  logic [3:0]      len;
  logic [5:0]      pad;
  logic [7:0]      sel_char;
  logic            sel_last;

  always_comb begin
    in_neg   = (item.command == itf_pkg::CMD_SDEC) && item.number[31];
    in_mag   = in_neg ? (32'd0 - item.number) : item.number;
    in_ptr   = (item.command == itf_pkg::CMD_PTR);
    in_hex   = (item.command == itf_pkg::CMD_LHEX) || (item.command == itf_pkg::CMD_UHEX)
               || in_ptr;
    in_width = (item.field_width > 6'(itf_pkg::MAX_WIDTH)) ? 6'(itf_pkg::MAX_WIDTH)
               : item.field_width;
  end

  always_comb begin
    for (int i = 0; i < itf_pkg::NUM_DIGITS; i++) begin
      adj[i] = (dig[i] >= 4'd5) ? (dig[i] + 4'd3) : dig[i];
    end
    shifted = {adj, bin[31]};
  end

  always_comb begin
    ndig = 4'd1;
    for (int i = 0; i < itf_pkg::NUM_DIGITS; i++) begin
      if (dig[i] != 4'd0) begin
        ndig = 4'(i + 1);
      end
    end
    len = ndig + {2'b0, pre};
    pad = (width > {2'b0, len}) ? (width - {2'b0, len}) : 6'd0;
  end

  always_comb begin
    sel_last = (pad_left == 6'd0) && (pre_left == 2'd0) && (dig_left == 4'd1);
    if (pad_left != 6'd0) begin
      sel_char = pad_zero ? itf_pkg::CH_ZERO : itf_pkg::CH_SPACE;
    end else if (pre_left != 2'd0) begin
      if (neg) begin
        sel_char = itf_pkg::CH_MINUS;
      end else begin
        sel_char = (pre_left == 2'd2) ? itf_pkg::CH_ZERO : itf_pkg::CH_X;
      end
    end else begin
      sel_char = itf_pkg::digit_char(dig[dig_left - 4'd1], upper);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg      <= in_neg;
      ptr      <= in_ptr;
      upper    <= (item.command == itf_pkg::CMD_UHEX);
      pad_zero <= item.pad_zero;
      width    <= in_ptr ? 6'd0 : in_width;
      pre      <= in_neg ? 2'd1 : (in_ptr ? 2'd2 : 2'd0);
      bin      <= in_mag;
      dig      <= in_hex ? {8'h00, in_mag} : 40'd0;
      cnt      <= 5'd0;
    end
    if (cmd.step) begin
      dig <= shifted[39:0];
      bin <= {bin[30:0], 1'b0};
      cnt <= cnt + 5'd1;
    end
    if (cmd.size) begin
      dig_left <= ndig;
      pad_left <= pad;
      pre_left <= pre;
    end
    if (cmd.emit) begin
      text.character <= sel_char;
      text.last      <= sel_last;
      if (pad_left != 6'd0) begin
        pad_left <= pad_left - 6'd1;
      end else if (pre_left != 2'd0) begin
        pre_left <= pre_left - 2'd1;
      end else begin
        dig_left <= dig_left - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (cmd.emit) begin
      text_valid <= 1'b1;
    end else if (!text_stall) begin
      text_valid <= 1'b0;
    end
  end

  always_comb begin
    status.cmd_ok    = (item.command <= itf_pkg::CMD_PTR);
    status.cmd_dec   = (item.command == itf_pkg::CMD_SDEC)
                       || (item.command == itf_pkg::CMD_UDEC);
    status.conv_done = (cnt == 5'(itf_pkg::NUM_BITS - 1));
    status.out_free  = !text_valid || !text_stall;
    status.emit_last = sel_last;
  end

`ifndef ASSERT_OFF
  a_digits_left: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (dig_left != 4'd0) && (dig_left <= 4'(itf_pkg::NUM_DIGITS)))
    else $error("digit counter out of range during emit");

  a_prefix_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (pre_left <= 2'd2) && !(ptr && neg))
    else $error("prefix counter out of range");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> text_valid && (text.last == $past(sel_last)))
    else $error("emitted character not presented");
`endif

endmodule

// ===== src/integer_to_text_formatter.sv =====
`timescale 1ns / 1ps

// Channel | Handshake               | Payload
// item    | item_valid, item_stall  | itf_pkg::item_t (command, number, field_width, pad_zero)
// text    | text_valid, text_stall  | itf_pkg::text_t (character, last)
//
// Decimal requests: an accept step, binary-to-BCD conversion (one bit per cycle), a sizing
// step, then one character per cycle while the text channel is not stalled. Hex and pointer
// requests skip the conversion. Commands 5 to 7 are accepted and dropped with no output.
// rst is synchronous and clears the controller state and the output valid.
// A stalled text channel holds emission; item_stall is high until the last character
// of the current request is loaded into the output register.

module integer_to_text_formatter (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  itf_pkg::item_t  item,
  output logic            text_valid,
  input  logic            text_stall,
  output itf_pkg::text_t  text
);

  itf_pkg::ctl_cmd_t   cmd;
  itf_pkg::dp_status_t status;

  itf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  itf_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

// ===== sim/integer_to_text_formatter_tb.sv =====
`timescale 1ns / 1ps

module integer_to_text_formatter_tb;

  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_COUNT   = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 3000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           item_valid = 1'b0;
  logic           item_stall;
  itf_pkg::item_t item = '0;
  logic           text_valid;
  logic           text_stall = 1'b0;
  itf_pkg::text_t text;

  itf_pkg::item_t pending_requests[$];
  itf_pkg::text_t expected_text[$];
  itf_pkg::text_t next_text;
  int    total_requests = 0;
  int    requests_accepted = 0;
  int    mismatches = 0;
  int    idle_cycles = 0;
  int    hold_left = 0;
  logic  hold_done = 1'b0;
  logic  sender_steady;
  logic  receiver_steady;

  assign sender_steady   = requests_accepted >= 40 && requests_accepted < 70;
  assign receiver_steady = requests_accepted >= 60 && requests_accepted < 90;

  integer_to_text_formatter u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text)
  );

  always #6 clk = ~clk;

  function automatic void format_request(input itf_pkg::item_t req);
    logic [7:0]     body[$];
    logic [7:0]     digits[$];
    logic [31:0]    mag;
    logic [31:0]    base;
    logic [31:0]    d;
    logic           upper;
    int             width;
    itf_pkg::text_t t;
    mag   = req.number;
    base  = 32'd10;
    upper = 1'b0;
    width = req.field_width;
    case (req.command)
      itf_pkg::CMD_SDEC: begin
        if (req.number[31]) begin
          body.push_back(itf_pkg::CH_MINUS);
          mag = 32'd0 - req.number;
        end
      end
      itf_pkg::CMD_UDEC: begin
      end
      itf_pkg::CMD_LHEX: base = 32'd16;
      itf_pkg::CMD_UHEX: begin
        base  = 32'd16;
        upper = 1'b1;
      end
      itf_pkg::CMD_PTR: begin
        base = 32'd16;
        body.push_back(itf_pkg::CH_ZERO);
        body.push_back(itf_pkg::CH_X);
        width = 0;
      end
      default: return;
    endcase
    do begin
      d = mag % base;
      if (d < 32'd10) begin
        digits.push_front(itf_pkg::CH_ZERO + d[7:0]);
      end else if (upper) begin
        digits.push_front(itf_pkg::CH_LOWER_A - itf_pkg::CASE_SHIFT + d[7:0] - 8'd10);
      end else begin
        digits.push_front(itf_pkg::CH_LOWER_A + d[7:0] - 8'd10);
      end
      mag = mag / base;
    end while (mag != 32'd0);
    foreach (digits[i]) body.push_back(digits[i]);
    if (width > itf_pkg::MAX_WIDTH) width = itf_pkg::MAX_WIDTH;
    for (int i = body.size(); i < width; i++) begin
      t.character = req.pad_zero ? itf_pkg::CH_ZERO : itf_pkg::CH_SPACE;
      t.last      = 1'b0;
      expected_text.push_back(t);
    end
    foreach (body[i]) begin
      t.character = body[i];
      t.last      = (i == body.size() - 1);
      expected_text.push_back(t);
    end
  endfunction

  task automatic add_request(input logic [2:0] command, input logic [31:0] number,
                             input int field_width, input logic pad_zero);
    itf_pkg::item_t req;
    req.command     = command;
    req.number      = number;
    req.field_width = field_width[5:0];
    req.pad_zero    = pad_zero;
    pending_requests.push_back(req);
  endtask

  function automatic logic [31:0] pick_number();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 9);
      1: return $urandom_range(0, 99999);
      2: return {1'b1, 31'($urandom)};
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        requests_accepted <= requests_accepted + 1;
      end
      if (!item_valid || !item_stall) begin
        if (pending_requests.size() != 0 && (sender_steady || $urandom_range(0, 99) >= 25)) begin
          item       <= pending_requests.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      text_stall <= 1'b0;
    end else if (hold_left != 0) begin
      text_stall <= 1'b1;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && requests_accepted >= 25) begin
      text_stall <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      text_stall <= !receiver_steady && $urandom_range(0, 99) < 25;
    end
  end

  // monitor: check the oldest expectation, then predict the newly accepted request
  always @(posedge clk) begin
    if (!rst) begin
      if (text_valid && !text_stall) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual %h last %b",
                   $time, text.character, text.last);
          mismatches++;
        end else begin
          next_text = expected_text.pop_front();
          if (text.character !== next_text.character) begin
            $display("%0t: character mismatch: expected %h, actual %h",
                     $time, next_text.character, text.character);
            mismatches++;
          end
          if (text.last !== next_text.last) begin
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, next_text.last, text.last);
            mismatches++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        format_request(item);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (text_valid && !text_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int valid_count;
    add_request(itf_pkg::CMD_SDEC, 32'h0000_0000, 0, 1'b0);
    add_request(itf_pkg::CMD_SDEC, 32'h8000_0000, 0, 1'b0);
    add_request(itf_pkg::CMD_SDEC, 32'h7FFF_FFFF, 0, 1'b1);
    add_request(itf_pkg::CMD_SDEC, 32'hFFFF_FFFB, 5, 1'b1);
    add_request(itf_pkg::CMD_SDEC, 32'hFFFF_FFFF, 63, 1'b0);
    add_request(itf_pkg::CMD_SDEC, 32'd12345, 3, 1'b1);
    add_request(itf_pkg::CMD_UDEC, 32'hFFFF_FFFF, 0, 1'b0);
    add_request(itf_pkg::CMD_UDEC, 32'h0000_0000, 63, 1'b1);
    add_request(itf_pkg::CMD_UDEC, 32'd42, 10, 1'b0);
    add_request(itf_pkg::CMD_LHEX, 32'hDEAD_BEEF, 0, 1'b0);
    add_request(itf_pkg::CMD_LHEX, 32'h0000_0000, 8, 1'b1);
    add_request(itf_pkg::CMD_UHEX, 32'hABCD_EF01, 12, 1'b0);
    add_request(itf_pkg::CMD_UHEX, 32'hFFFF_FFFF, 63, 1'b1);
    add_request(itf_pkg::CMD_PTR, 32'h0000_0000, 20, 1'b1);
    add_request(itf_pkg::CMD_PTR, 32'hFFFF_FFFF, 0, 1'b0);
    add_request(itf_pkg::CMD_PTR, 32'h0123_ABCD, 63, 1'b0);
    add_request(3'(itf_pkg::CMD_PTR + 3'd1), 32'h1234_5678, 5, 1'b1);
    add_request(3'(itf_pkg::CMD_PTR + 3'd2), 32'hFFFF_FFFF, 63, 1'b0);
    add_request(3'(itf_pkg::CMD_PTR + 3'd3), 32'h0000_0000, 0, 1'b1);
    valid_count = 0;
    while (valid_count < RANDOM_COUNT) begin
      if ($urandom_range(0, 99) < 10) begin
        add_request(3'(itf_pkg::CMD_PTR + 3'($urandom_range(1, 3))), $urandom,
                    $urandom_range(0, 63), 1'($urandom));
      end else begin
        add_request(3'($urandom_range(itf_pkg::CMD_SDEC, itf_pkg::CMD_PTR)), pick_number(),
                    ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                                 : $urandom_range(13, 63),
                    1'($urandom));
        valid_count++;
      end
    end
    total_requests = pending_requests.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (requests_accepted < total_requests || expected_text.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/itf_pkg.sv
src/itf_ctrl.sv
src/itf_dpath.sv
src/integer_to_text_formatter.sv
sim/integer_to_text_formatter_tb.sv
